FILE: rtl/spqvt_pkg.sv
package spqvt_pkg;

  localparam int CfgW        = 14;
  localparam int CfgIdxW     = 3;
  localparam int CordicSteps = 14;
  localparam int QuotW       = 16;

  localparam logic [CfgW-1:0] ViewportWReset = 14'd1280;
  localparam logic [CfgW-1:0] ViewportHReset = 14'd720;
  localparam logic [CfgW-1:0] TextureWReset  = 14'd256;
  localparam logic [CfgW-1:0] TextureHReset  = 14'd256;

  // CORDIC start vector: 1/K in Q1.14.
  localparam logic signed [17:0] CordicX0 = 18'sd9949;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VIEWPORT_W = 3'd0,
    REG_VIEWPORT_H = 3'd1,
    REG_TEXTURE_W  = 3'd2,
    REG_TEXTURE_H  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        rect_x;
    logic [15:0]        rect_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic [15:0]        angle;
  } request_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               last;
  } result_t;

  // One corner as it leaves the sequencer.
  typedef struct packed {
    logic [1:0]         corner;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [16:0]        tx;
    logic [16:0]        ty;
    logic [15:0]        angle;
  } corner_t;

  // Geometry that rides along the CORDIC pipeline.
  typedef struct packed {
    logic [1:0]         corner;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [16:0]        tx;
    logic [16:0]        ty;
  } geom_t;

  function automatic logic signed [17:0] atan_val(input int i);
    logic signed [17:0] r;
    case (i)
      0:       r = 18'sd8192;
      1:       r = 18'sd4836;
      2:       r = 18'sd2555;
      3:       r = 18'sd1297;
      4:       r = 18'sd651;
      5:       r = 18'sd326;
      6:       r = 18'sd163;
      7:       r = 18'sd81;
      8:       r = 18'sd41;
      9:       r = 18'sd20;
      10:      r = 18'sd10;
      11:      r = 18'sd5;
      12:      r = 18'sd3;
      default: r = 18'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/spqvt_front.sv
module spqvt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spqvt_pkg::request_t req,
  output logic                busy,
  output logic                out_valid,
  output spqvt_pkg::corner_t  out_item
);

  spqvt_pkg::request_t sprite;
  spqvt_pkg::corner_t  item_next;
  logic                active;
  logic [1:0]          cnt;
  logic                accept;
  logic                zero;
  logic [15:0]         wsel;
  logic [15:0]         hsel;

  assign busy   = active && (cnt != 2'd3);
  assign accept = start && !busy;
  assign zero   = (req.scale_x == 16'sd0) || (req.scale_y == 16'sd0) ||
                  (req.rect_w == 16'd0) || (req.rect_h == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= active;
      if (accept) begin
        active <= !zero;
        cnt    <= 2'd0;
      end else if (active) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sprite <= req;
    end
    out_item <= item_next;
  end

  always_comb begin
    wsel = cnt[0] ? sprite.rect_w : 16'd0;
    hsel = cnt[1] ? sprite.rect_h : 16'd0;
    item_next.corner  = cnt;
    item_next.ax      = $signed({2'b00, wsel}) -
                        $signed({{2{sprite.pivot_x[15]}}, sprite.pivot_x});
    item_next.ay      = $signed({2'b00, hsel}) -
                        $signed({{2{sprite.pivot_y[15]}}, sprite.pivot_y});
    item_next.scale_x = sprite.scale_x;
    item_next.scale_y = sprite.scale_y;
    item_next.pos_x   = sprite.pos_x;
    item_next.pos_y   = sprite.pos_y;
    item_next.tx      = {1'b0, sprite.rect_x} + {1'b0, wsel};
    item_next.ty      = {1'b0, sprite.rect_y} + {1'b0, hsel};
    item_next.angle   = sprite.angle;
  end

endmodule

FILE: rtl/spqvt_cordic.sv
module spqvt_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [15:0]        angle,
  input  spqvt_pkg::geom_t   in_geom,
  output logic               out_valid,
  output logic signed [17:0] cos_q,
  output logic signed [17:0] sin_q,
  output spqvt_pkg::geom_t   out_geom
);

  localparam int N = spqvt_pkg::CordicSteps;

  logic signed [17:0] xs [0:N];
  logic signed [17:0] ys [0:N];
  logic signed [17:0] zs [0:N];
  logic [1:0]         qd [0:N];
  spqvt_pkg::geom_t   gp [0:N];
  logic               vld [0:N];

  logic [1:0]  quad_in;
  logic [15:0] zred;

  // Nearest quarter turn is split off and reapplied exactly at the end.
  always_comb begin
    quad_in = angle[15:14] + {1'b0, angle[13]};
    zred    = angle - {quad_in, 14'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= spqvt_pkg::CordicX0;
    ys[0] <= 18'sd0;
    zs[0] <= $signed({{2{zred[15]}}, zred});
    qd[0] <= quad_in;
    gp[0] <= in_geom;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (zs[i] >= 18'sd0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - spqvt_pkg::atan_val(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + spqvt_pkg::atan_val(i);
      end
      qd[i+1] <= qd[i];
      gp[i+1] <= gp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    out_geom <= gp[N];
    unique case (qd[N])
      2'd1: begin
        cos_q <= -ys[N];
        sin_q <= xs[N];
      end
      2'd2: begin
        cos_q <= -xs[N];
        sin_q <= -ys[N];
      end
      2'd3: begin
        cos_q <= ys[N];
        sin_q <= -xs[N];
      end
      default: begin
        cos_q <= xs[N];
        sin_q <= ys[N];
      end
    endcase
  end

endmodule

FILE: rtl/spqvt_div.sv
module spqvt_div #(
  parameter int NW = 45,
  parameter int DW = 15,
  parameter int QW = spqvt_pkg::QuotW,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int RW = DW + QW;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [RW-1:0] rem  [0:QW];
  logic [DW-1:0] dv   [0:QW];
  logic [QW-1:0] qb   [0:QW];
  logic          of   [0:QW];
  logic [SW-1:0] sd   [0:QW];
  logic          vld  [0:QW];

  logic [CW-1:0] num_c;
  logic [CW-1:0] den_top;

  // A quotient that does not fit in QW bits only raises the overflow flag.
  assign num_c   = CW'(num);
  assign den_top = CW'({den, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num_c[RW-1:0];
    dv[0]  <= den;
    qb[0]  <= '0;
    of[0]  <= (num_c >= den_top);
    sd[0]  <= side_in;
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    logic [RW:0] trial;
    assign trial = {1'b0, rem[s]} - {1'b0, (RW'(dv[s]) << (QW - 1 - s))};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!trial[RW]) begin
        rem[s+1] <= trial[RW-1:0];
        qb[s+1]  <= qb[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem[s+1] <= rem[s];
        qb[s+1]  <= qb[s];
      end
      dv[s+1] <= dv[s];
      of[s+1] <= of[s];
      sd[s+1] <= sd[s];
    end
  end

  assign out_valid = vld[QW];
  assign quot      = qb[QW];
  assign ovf       = of[QW];
  assign side_out  = sd[QW];

endmodule

FILE: rtl/sprite_quad_vertex_transform.sv
// Sprite quad vertex transform.
// A request carries one sprite: position, scale, texture rectangle, pivot
// and angle. It is taken at a rising edge where start is high and busy is
// low. The block then returns the four corners of the quad in strip order,
// one per cycle on consecutive cycles, each marked by result_valid for one
// cycle; the fourth corner has last set. A sprite with a zero scale or a
// zero rectangle size is taken and produces nothing.
// The corner sequencer issues one corner per cycle and so sets the
// throughput; busy is high after a request while its remaining corners are
// issued, and a new request can be taken in the cycle that issues the last
// corner. The 14 CORDIC steps and the 16-bit restoring dividers make up most
// of the pipeline between a request and its first corner.
// The receiver cannot stall, so nothing inside the pipeline ever waits.
// The configuration channel (cfg_valid/cfg_ready) writes the viewport and
// texture sizes; it is always ready. Synchronous reset empties the pipeline
// and restores the default register values.
module sprite_quad_vertex_transform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  spqvt_pkg::request_t                 req,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spqvt_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [spqvt_pkg::CfgW-1:0]          cfg_data,
  output logic                                result_valid,
  output spqvt_pkg::result_t                  result
);

  // Configuration registers; a zero value acts as one in the divisions.
  logic [13:0] vw;
  logic [13:0] vh;
  logic [13:0] tw;
  logic [13:0] th;
  logic [13:0] vw_e;
  logic [13:0] vh_e;
  logic [13:0] tw_e;
  logic [13:0] th_e;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= spqvt_pkg::ViewportWReset;
      vh <= spqvt_pkg::ViewportHReset;
      tw <= spqvt_pkg::TextureWReset;
      th <= spqvt_pkg::TextureHReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spqvt_pkg::REG_VIEWPORT_W: vw <= cfg_data;
        spqvt_pkg::REG_VIEWPORT_H: vh <= cfg_data;
        spqvt_pkg::REG_TEXTURE_W:  tw <= cfg_data;
        spqvt_pkg::REG_TEXTURE_H:  th <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vw_e = (vw == 14'd0) ? 14'd1 : vw;
  assign vh_e = (vh == 14'd0) ? 14'd1 : vh;
  assign tw_e = (tw == 14'd0) ? 14'd1 : tw;
  assign th_e = (th == 14'd0) ? 14'd1 : th;

  // Corner sequencer: one request becomes four corners.
  logic               fr_valid;
  spqvt_pkg::corner_t fr_item;

  spqvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .out_valid (fr_valid),
    .out_item  (fr_item)
  );

  // Scaled offset of the corner from the pivot, in Q.12 pixels.
  logic             p1_valid;
  spqvt_pkg::geom_t p1_geom;
  logic [15:0]      p1_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= fr_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_geom.corner <= fr_item.corner;
    p1_geom.dx     <= 34'(fr_item.scale_x * fr_item.ax);
    p1_geom.dy     <= 34'(fr_item.scale_y * fr_item.ay);
    p1_geom.pos_x  <= fr_item.pos_x;
    p1_geom.pos_y  <= fr_item.pos_y;
    p1_geom.tx     <= fr_item.tx;
    p1_geom.ty     <= fr_item.ty;
    p1_angle       <= fr_item.angle;
  end

  // Sine and cosine of the angle in Q1.14.
  logic               c_valid;
  logic signed [17:0] cs;
  logic signed [17:0] sn;
  spqvt_pkg::geom_t   c_geom;

  spqvt_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .angle     (p1_angle),
    .in_geom   (p1_geom),
    .out_valid (c_valid),
    .cos_q     (cs),
    .sin_q     (sn),
    .out_geom  (c_geom)
  );

  // Rotation products.
  logic               m_valid;
  logic signed [51:0] m_xc;
  logic signed [51:0] m_ys;
  logic signed [51:0] m_xs;
  logic signed [51:0] m_yc;
  spqvt_pkg::geom_t   m_geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_xc   <= 52'(c_geom.dx * cs);
    m_ys   <= 52'(c_geom.dy * sn);
    m_xs   <= 52'(c_geom.dx * sn);
    m_yc   <= 52'(c_geom.dy * cs);
    m_geom <= c_geom;
  end

  // Rotated corner plus position, in Q.26 pixels.
  logic               a_valid;
  logic signed [53:0] a_x;
  logic signed [53:0] a_y;
  spqvt_pkg::geom_t   a_geom;
  logic signed [53:0] pos_x_w;
  logic signed [53:0] pos_y_w;

  assign pos_x_w = 54'(m_geom.pos_x) <<< 22;
  assign pos_y_w = 54'(m_geom.pos_y) <<< 22;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_x    <= 54'(m_xc) - 54'(m_ys) + pos_x_w;
    a_y    <= 54'(m_xs) + 54'(m_yc) + pos_y_w;
    a_geom <= m_geom;
  end

  // Division operands. Rounding to nearest of 2|X| / (vw * 4096) reduces to
  // floor(((|X| >> 10) + vw) / (2 * vw)); the dropped low bits never carry
  // the quotient across an integer.
  logic        pr_valid;
  logic [44:0] pr_nx;
  logic [44:0] pr_ny;
  logic [27:0] pr_nu;
  logic [27:0] pr_nv;
  logic [14:0] pr_dx;
  logic [14:0] pr_dy;
  logic [13:0] pr_du;
  logic [13:0] pr_dv;
  logic [3:0]  pr_side;
  logic [53:0] mag_x;
  logic [53:0] mag_y;

  assign mag_x = a_x[53] ? 54'(-a_x) : 54'(a_x);
  assign mag_y = a_y[53] ? 54'(-a_y) : 54'(a_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    pr_nx   <= 45'(mag_x[53:10]) + 45'(vw_e);
    pr_ny   <= 45'(mag_y[53:10]) + 45'(vh_e);
    pr_dx   <= {vw_e, 1'b0};
    pr_dy   <= {vh_e, 1'b0};
    pr_nu   <= 28'({a_geom.tx, 10'd0}) + 28'(tw_e[13:1]);
    pr_nv   <= 28'({a_geom.ty, 10'd0}) + 28'(th_e[13:1]);
    pr_du   <= tw_e;
    pr_dv   <= th_e;
    pr_side <= {a_geom.corner, a_x[53], a_y[53]};
  end

  // Four dividers in lockstep; the x divider carries corner and signs.
  logic        dx_valid;
  logic [15:0] q_x;
  logic [15:0] q_y;
  logic [15:0] q_u;
  logic [15:0] q_v;
  logic        of_x;
  logic        of_y;
  logic        of_u;
  logic        of_v;
  logic [3:0]  d_side;

  spqvt_div #(.NW(45), .DW(15), .QW(spqvt_pkg::QuotW), .SW(4)) u_div_x (
    .clk (clk), .rst (rst), .in_valid (pr_valid), .num (pr_nx), .den (pr_dx),
    .side_in (pr_side), .out_valid (dx_valid), .quot (q_x), .ovf (of_x),
    .side_out (d_side)
  );

  spqvt_div #(.NW(45), .DW(15), .QW(spqvt_pkg::QuotW), .SW(1)) u_div_y (
    .clk (clk), .rst (rst), .in_valid (pr_valid), .num (pr_ny), .den (pr_dy),
    .side_in (1'b0), .out_valid (), .quot (q_y), .ovf (of_y), .side_out ()
  );

  spqvt_div #(.NW(28), .DW(14), .QW(spqvt_pkg::QuotW), .SW(1)) u_div_u (
    .clk (clk), .rst (rst), .in_valid (pr_valid), .num (pr_nu), .den (pr_du),
    .side_in (1'b0), .out_valid (), .quot (q_u), .ovf (of_u), .side_out ()
  );

  spqvt_div #(.NW(28), .DW(14), .QW(spqvt_pkg::QuotW), .SW(1)) u_div_v (
    .clk (clk), .rst (rst), .in_valid (pr_valid), .num (pr_nv), .den (pr_dv),
    .side_in (1'b0), .out_valid (), .quot (q_v), .ovf (of_v), .side_out ()
  );

  // Sign, offset and saturation of the results.
  logic [16:0]        qx17;
  logic [16:0]        qy17;
  logic signed [18:0] svx;
  logic signed [18:0] svy;
  spqvt_pkg::result_t result_next;

  always_comb begin
    qx17 = of_x ? 17'h10000 : {1'b0, q_x};
    qy17 = of_y ? 17'h10000 : {1'b0, q_y};
    svx  = d_side[1] ? -$signed(19'(qx17)) : $signed(19'(qx17));
    svy  = d_side[0] ? -$signed(19'(qy17)) : $signed(19'(qy17));
    result_next.corner = d_side[3:2];
    result_next.ndc_x  = spqvt_pkg::sat16(svx - 19'sd16384);
    result_next.ndc_y  = spqvt_pkg::sat16(19'sd16384 - svy);
    result_next.tex_u  = (of_u || q_u[15]) ? 16'sh7FFF : $signed(q_u);
    result_next.tex_v  = (of_v || q_v[15]) ? 16'sh7FFF : $signed(q_v);
    result_next.last   = (d_side[3:2] == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  logic in_zero;
  assign in_zero = (req.scale_x == 16'sd0) || (req.scale_y == 16'sd0) ||
                   (req.rect_w == 16'd0) || (req.rect_h == 16'd0);

  // A usable sprite holds the request side off while its corners issue.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !in_zero) |=> busy)
    else $error("busy not raised after a sprite request");

  // Corners of one quad leave on consecutive cycles in order.
  a_corner_sequence: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.corner != 2'd3)) |=>
      (result_valid && (result.corner == $past(result.corner) + 2'd1)))
    else $error("corner sequence broken");

  // A quad starts with its first corner.
  a_quad_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> (result.corner == 2'd0))
    else $error("quad did not start at corner zero");

endmodule

FILE: verif/tb_sprite_quad_vertex_transform.sv
`timescale 1ns / 1ps

module tb_sprite_quad_vertex_transform;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [spqvt_pkg::CfgIdxW-1:0] REG_UNMAPPED = 3'd5;
  // Covers the pipeline from a request to its first corner, with margin.
  localparam int DrainCycles = 60;
  localparam int RandomItems = 400;
  localparam int Phases = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  spqvt_pkg::request_t req = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spqvt_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [spqvt_pkg::CfgW-1:0] cfg_data = '0;
  logic result_valid;
  spqvt_pkg::result_t result;

  sprite_quad_vertex_transform u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Our own copy of the four size registers, updated when a write is taken.
  logic [spqvt_pkg::CfgW-1:0] vp_w = spqvt_pkg::ViewportWReset;
  logic [spqvt_pkg::CfgW-1:0] vp_h = spqvt_pkg::ViewportHReset;
  logic [spqvt_pkg::CfgW-1:0] tex_w = spqvt_pkg::TextureWReset;
  logic [spqvt_pkg::CfgW-1:0] tex_h = spqvt_pkg::TextureHReset;

  // Corners predicted for accepted sprites, oldest first.
  spqvt_pkg::result_t pending_corners[$];
  int error_count = 0;
  int sprites_sent = 0;
  int corners_seen = 0;
  int empty_sprites = 0;

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_round(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Cosine and sine in Q1.14: the nearest quarter turn is taken out exactly,
  // the rest goes through 14 CORDIC rotations. >>> on a signed longint
  // rounds toward minus infinity, as the hardware shift does.
  task automatic angle_to_cos_sin(input logic [15:0] ang, output longint c, output longint s);
    int quad;
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    quad = ((int'(ang) + 8192) >> 14) & 3;
    z = longint'(ang) - quad * 16384;
    if (z > 32767) z -= 65536;
    x = 9949;
    y = 0;
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= steps[i];
      end else begin
        x = x + ys; y = y - xs; z += steps[i];
      end
    end
    case (quad)
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endtask

  // Works out the quad corners of one sprite under the current registers.
  task automatic quad_corners(input spqvt_pkg::request_t r, output spqvt_pkg::result_t q[4],
                              output int n);
    longint c, s, dx, dy, px, py, vw, vh, tw, th, cx, cy;
    longint sx, sy;
    n = 0;
    if (r.scale_x == 0 || r.scale_y == 0 || r.rect_w == 0 || r.rect_h == 0) return;
    vw = (vp_w == 0) ? 1 : vp_w;
    vh = (vp_h == 0) ? 1 : vp_h;
    tw = (tex_w == 0) ? 1 : tex_w;
    th = (tex_h == 0) ? 1 : tex_h;
    sx = r.scale_x;
    sy = r.scale_y;
    angle_to_cos_sin(r.angle, c, s);
    for (int k = 0; k < 4; k++) begin
      cx = k & 1;
      cy = (k >> 1) & 1;
      dx = cx * longint'(r.rect_w) * sx - sx * longint'(r.pivot_x);
      dy = cy * longint'(r.rect_h) * sy - sy * longint'(r.pivot_y);
      px = dx * c - dy * s + longint'(r.pos_x) * 4194304;
      py = dx * s + dy * c + longint'(r.pos_y) * 4194304;
      q[k].corner = k[1:0];
      q[k].ndc_x = clamp16(div_round(px * 2, vw << 12) - 16384);
      q[k].ndc_y = clamp16(16384 - div_round(py * 2, vh << 12));
      q[k].tex_u = clamp16(div_round((longint'(r.rect_x) + cx * r.rect_w) * 1024, tw));
      q[k].tex_v = clamp16(div_round((longint'(r.rect_y) + cy * r.rect_h) * 1024, th));
      q[k].last = (k == 3);
    end
    n = 4;
  endtask

  // Every corner on the result port is checked against the oldest prediction.
  always @(posedge clk) begin
    spqvt_pkg::result_t e;
    if (!rst && result_valid) begin
      corners_seen++;
      if (pending_corners.size() == 0) begin
        $error("unexpected corner %0d", result.corner);
        error_count++;
      end else begin
        e = pending_corners.pop_front();
        if (result.corner !== e.corner) begin
          $error("corner: expected %0d, got %0d", e.corner, result.corner); error_count++;
        end
        if (result.ndc_x !== e.ndc_x) begin
          $error("ndc_x: expected %0d, got %0d", e.ndc_x, result.ndc_x); error_count++;
        end
        if (result.ndc_y !== e.ndc_y) begin
          $error("ndc_y: expected %0d, got %0d", e.ndc_y, result.ndc_y); error_count++;
        end
        if (result.tex_u !== e.tex_u) begin
          $error("tex_u: expected %0d, got %0d", e.tex_u, result.tex_u); error_count++;
        end
        if (result.tex_v !== e.tex_v) begin
          $error("tex_v: expected %0d, got %0d", e.tex_v, result.tex_v); error_count++;
        end
        if (result.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, result.last); error_count++;
        end
      end
    end
  end

  // Writes one register; the channel is taken at an edge where ready is high.
  // Valid stays high so that writes can follow back to back; the caller drops it.
  task automatic write_reg(input logic [spqvt_pkg::CfgIdxW-1:0] idx,
                           input logic [spqvt_pkg::CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      spqvt_pkg::REG_VIEWPORT_W: vp_w = val;
      spqvt_pkg::REG_VIEWPORT_H: vp_h = val;
      spqvt_pkg::REG_TEXTURE_W: tex_w = val;
      spqvt_pkg::REG_TEXTURE_H: tex_h = val;
      default: ;
    endcase
  endtask

  // Waits until every predicted corner is out, then lets the pipeline drain
  // before anything else changes.
  task automatic wait_idle();
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Sends one sprite after a random gap. When the gap is zero start stays high
  // and the next request is taken as soon as busy is low.
  task automatic send_sprite(input spqvt_pkg::request_t r, output spqvt_pkg::result_t q[4],
                             output int n);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    quad_corners(r, q, n);
    for (int k = 0; k < n; k++) pending_corners.push_back(q[k]);
    sprites_sent++;
    if (n == 0) empty_sprites++;
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly modest sprites that stay on screen; some with every field random.
  function automatic spqvt_pkg::request_t random_sprite();
    spqvt_pkg::request_t r;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(spqvt_pkg::request_t)-1:0];
    if ($urandom_range(0, 3) != 0) begin
      r.scale_x = 16'($signed($urandom_range(0, 1023)) - 512);
      r.scale_y = 16'($signed($urandom_range(0, 1023)) - 512);
      r.rect_w = 16'($urandom_range(1, 4096));
      r.rect_h = 16'($urandom_range(1, 4096));
      r.pivot_x = 16'($signed($urandom_range(0, 2047)) - 1024);
      r.pivot_y = 16'($signed($urandom_range(0, 2047)) - 1024);
      r.pos_x = 16'($urandom_range(0, 20479));
      r.pos_y = 16'($urandom_range(0, 11519));
    end
    case ($urandom_range(0, 24))
      0: r.scale_x = '0;
      1: r.scale_y = '0;
      2: r.rect_w = '0;
      3: r.rect_h = '0;
      default: ;
    endcase
    return r;
  endfunction

  typedef struct {
    spqvt_pkg::request_t sprite;
    bit typed;            // corner 0 below is known by inspection
    spqvt_pkg::result_t first_corner;
  } sprite_row_t;

  // Unit scale, no pivot, no rotation, sprite at the origin, 1-texel rect.
  function automatic spqvt_pkg::request_t plain_sprite();
    spqvt_pkg::request_t r;
    r = '0;
    r.scale_x = 16'sd256;
    r.scale_y = 16'sd256;
    r.rect_w = 16'd16;
    r.rect_h = 16'd16;
    return r;
  endfunction

  sprite_row_t directed_rows[$];

  task automatic build_directed();
    sprite_row_t row;
    logic [15:0] turns[7] = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152,
                               16'd57344, 16'hFFFF};
    // Plain sprite at the origin: corner 0 sits on the top-left of the screen.
    row.sprite = plain_sprite();
    row.typed = 1;
    row.first_corner = '{corner: 2'd0, ndc_x: -16'sd16384, ndc_y: 16'sd16384,
                         tex_u: 16'sd0, tex_v: 16'sd0, last: 1'b0};
    directed_rows.push_back(row);
    // Position at both extremes and one texture origin at its top: all but the other texture coordinate saturate.
    row.sprite = plain_sprite();
    row.sprite.pos_x = 16'sh7FFF;
    row.sprite.pos_y = 16'sh8000;
    row.sprite.rect_x = 16'hFFFF;
    row.first_corner = '{corner: 2'd0, ndc_x: 16'sh7FFF, ndc_y: 16'sh7FFF,
                         tex_u: 16'sh7FFF, tex_v: 16'sd0, last: 1'b0};
    directed_rows.push_back(row);
    row.sprite.pos_x = 16'sh8000;
    row.sprite.pos_y = 16'sh7FFF;
    row.sprite.rect_y = 16'hFFFF;
    row.sprite.rect_x = 16'd0;
    row.first_corner = '{corner: 2'd0, ndc_x: 16'sh8000, ndc_y: 16'sh8000,
                         tex_u: 16'sd0, tex_v: 16'sh7FFF, last: 1'b0};
    directed_rows.push_back(row);
    row.typed = 0;
    // A zero scale or size on any axis yields no corners.
    for (int i = 0; i < 4; i++) begin
      row.sprite = plain_sprite();
      case (i)
        0: row.sprite.scale_x = '0;
        1: row.sprite.scale_y = '0;
        2: row.sprite.rect_w = '0;
        default: row.sprite.rect_h = '0;
      endcase
      directed_rows.push_back(row);
    end
    // Rotation at each quarter turn, two of the octants and the wrap-around angle.
    foreach (turns[i]) begin
      row.sprite = plain_sprite();
      row.sprite.pos_x = 16'sd10240;
      row.sprite.pos_y = 16'sd5760;
      row.sprite.pivot_x = 16'sd8;
      row.sprite.pivot_y = 16'sd8;
      row.sprite.angle = turns[i];
      directed_rows.push_back(row);
    end
    // Largest scales and sizes, negative scales, extreme pivots.
    row.sprite = plain_sprite();
    row.sprite.scale_x = 16'sh7FFF;
    row.sprite.scale_y = 16'sh8000;
    row.sprite.rect_w = 16'hFFFF;
    row.sprite.rect_h = 16'hFFFF;
    row.sprite.pivot_x = 16'sh8000;
    row.sprite.pivot_y = 16'sh7FFF;
    row.sprite.angle = 16'd12345;
    directed_rows.push_back(row);
    row.sprite.scale_x = -16'sd1;
    row.sprite.scale_y = 16'sd1;
    row.sprite.pivot_x = 16'sh7FFF;
    row.sprite.pivot_y = 16'sh8000;
    directed_rows.push_back(row);
    row.sprite = plain_sprite();
    row.sprite.scale_x = -16'sd256;
    row.sprite.scale_y = -16'sd256;
    row.sprite.angle = 16'd40000;
    directed_rows.push_back(row);
  endtask

  initial begin
    spqvt_pkg::result_t q[4];
    int n;
    logic [spqvt_pkg::CfgW-1:0] sizes[4];
    build_directed();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sprites under the reset register values.
    foreach (directed_rows[i]) begin
      send_sprite(directed_rows[i].sprite, q, n);
      if (directed_rows[i].typed && q[0] != directed_rows[i].first_corner) begin
        $error("directed sprite %0d: corner 0 differs from the hand value", i);
        error_count++;
      end
    end
    stop_sending();

    // Random sprites over several register settings; each change of setting
    // is made with the block drained, which also pauses the sender.
    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      case (p)
        0: sizes = '{14'd1, 14'd1, 14'd1, 14'd1};
        1: sizes = '{14'd8192, 14'd8192, 14'd8192, 14'd8192};
        2: sizes = '{14'd0, 14'd16383, 14'd0, 14'd16383};
        3: sizes = '{14'd16383, 14'd0, 14'd16383, 14'd0};
        default: sizes = '{14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                           14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192))};
      endcase
      write_reg(spqvt_pkg::REG_VIEWPORT_W, sizes[0]);
      write_reg(spqvt_pkg::REG_VIEWPORT_H, sizes[1]);
      write_reg(spqvt_pkg::REG_TEXTURE_W, sizes[2]);
      write_reg(spqvt_pkg::REG_TEXTURE_H, sizes[3]);
      write_reg(REG_UNMAPPED, 14'($urandom));
      cfg_valid <= 1'b0;
      for (int i = 0; i < RandomItems / Phases; i++) send_sprite(random_sprite(), q, n);
      stop_sending();
    end

    wait_idle();
    $display("Sent %0d sprites (%0d with no corners) over %0d register settings;",
             sprites_sent, empty_sprites, Phases + 1);
    $display("checked %0d corners.", corners_seen);
    if (error_count == 0) begin
      $display("tb_sprite_quad_vertex_transform OK");
    end else begin
      $display("tb_sprite_quad_vertex_transform NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_sprite_quad_vertex_transform NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/spqvt_pkg.sv
rtl/spqvt_front.sv
rtl/spqvt_cordic.sv
rtl/spqvt_div.sv
rtl/sprite_quad_vertex_transform.sv
verif/tb_sprite_quad_vertex_transform.sv
